>>> src/tm_pkg.sv
package tm_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int DEGREE_W   = 16;

  localparam logic [CFG_DATA_W-1:0] CORNER_MIN = '0;
  localparam logic [CFG_DATA_W-1:0] CORNER_MAX = '1;

  typedef enum logic [1:0] {
    CFG_CORNER_ONE   = 2'd0,
    CFG_CORNER_TWO   = 2'd1,
    CFG_CORNER_THREE = 2'd2,
    CFG_CORNER_FOUR  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_RISE = 2'd2,
    KIND_FALL = 2'd3
  } deg_kind_t;

endpackage

>>> src/tm_in_if.sv
interface tm_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> src/tm_out_if.sv
interface tm_out_if
  import tm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DEGREE_W-1:0] degree;
  logic                in_support;

  modport source (output valid, output degree, output in_support, input ready);
  modport sink (input valid, input degree, input in_support, output ready);
endinterface

>>> src/tm_cfg_if.sv
interface tm_cfg_if
  import tm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/trapezoid_membership.sv
// Trapezoidal fuzzy membership of an unsigned sample stream.
//
// cfg_ch writes the four corners (index 0..3: corner one to four). Writes are
// always accepted and must only be issued while no transaction is in flight.
// in_ch carries one sample per transaction; out_ch returns one transaction per
// sample with the membership degree (1 << FRAC_BITS means 1.0) and the flag
// that the sample lies within corner one to corner four, in input order.
//
// Throughput: one sample per cycle unless out_ch.ready stalls the pipeline.
// The ramp quotient comes from a restoring divider unrolled into FRAC_BITS
// stages, one quotient bit per stage, behind a compare stage and a subtract
// stage; an output register follows the divider.
//
// Reset empties the pipeline and loads the corners 0, 0, 65535, 65535.
// When out_ch.ready is low while a result is held, the whole pipeline holds
// and in_ch.ready drops; nothing is lost or repeated.
module trapezoid_membership
  import tm_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  tm_cfg_if.sink     cfg_ch,
  tm_in_if.sink      in_ch,
  tm_out_if.source   out_ch
);

  localparam int DW = DATA_WIDTH;
  localparam int FW = FRAC_BITS;

  logic [DW-1:0] corner_one_r;
  logic [DW-1:0] corner_two_r;
  logic [DW-1:0] corner_three_r;
  logic [DW-1:0] corner_four_r;

  logic          adv;

  logic          a_vld_r;
  logic [DW-1:0] a_sample_r;
  deg_kind_t     a_kind_r;
  logic          a_sup_r;
  deg_kind_t     a_kind_nxt;
  logic          a_sup_nxt;

  logic          b_vld_r;
  logic [DW-1:0] b_num_r;
  logic [DW-1:0] b_den_r;
  deg_kind_t     b_kind_r;
  logic          b_sup_r;
  logic [DW-1:0] b_num_nxt;
  logic [DW-1:0] b_den_nxt;

  logic          dv_vld_r  [FW];
  logic [DW-1:0] dv_rem_r  [FW];
  logic [DW-1:0] dv_den_r  [FW];
  logic [FW-1:0] dv_quot_r [FW];
  deg_kind_t     dv_kind_r [FW];
  logic          dv_sup_r  [FW];

  logic          dv_vld_in  [FW];
  logic [DW-1:0] dv_rem_in  [FW];
  logic [DW-1:0] dv_den_in  [FW];
  logic [FW-1:0] dv_quot_in [FW];
  deg_kind_t     dv_kind_in [FW];
  logic          dv_sup_in  [FW];

  logic                out_valid_r;
  logic [DEGREE_W-1:0] out_degree_r;
  logic                out_sup_r;
  logic [FW:0]         deg_nxt;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_one_r   <= DW'(CORNER_MIN);
      corner_two_r   <= DW'(CORNER_MIN);
      corner_three_r <= DW'(CORNER_MAX);
      corner_four_r  <= DW'(CORNER_MAX);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_CORNER_ONE:   corner_one_r   <= DW'(cfg_ch.data);
        CFG_CORNER_TWO:   corner_two_r   <= DW'(cfg_ch.data);
        CFG_CORNER_THREE: corner_three_r <= DW'(cfg_ch.data);
        CFG_CORNER_FOUR:  corner_four_r  <= DW'(cfg_ch.data);
      endcase
    end
  end

  // classify the sample against the corners
  always_comb begin
    priority if (in_ch.sample <= corner_one_r) begin
      a_kind_nxt = KIND_ZERO;
    end else if (in_ch.sample < corner_two_r) begin
      a_kind_nxt = KIND_RISE;
    end else if (in_ch.sample <= corner_three_r) begin
      a_kind_nxt = KIND_ONE;
    end else if (in_ch.sample < corner_four_r) begin
      a_kind_nxt = KIND_FALL;
    end else begin
      a_kind_nxt = KIND_ZERO;
    end
    a_sup_nxt = (in_ch.sample >= corner_one_r) && (in_ch.sample <= corner_four_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sample_r <= in_ch.sample;
      a_kind_r   <= a_kind_nxt;
      a_sup_r    <= a_sup_nxt;
    end
  end

  // form ramp numerator and denominator
  always_comb begin
    if (a_kind_r == KIND_FALL) begin
      b_num_nxt = corner_four_r - a_sample_r;
      b_den_nxt = corner_four_r - corner_three_r;
    end else begin
      b_num_nxt = a_sample_r - corner_one_r;
      b_den_nxt = corner_two_r - corner_one_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_num_r  <= b_num_nxt;
      b_den_r  <= b_den_nxt;
      b_kind_r <= a_kind_r;
      b_sup_r  <= a_sup_r;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < FW; k++) begin : g_div
    logic [DW+1:0] diff;
    logic          borrow;

    if (k == 0) begin : g_first
      assign dv_vld_in[k]  = b_vld_r;
      assign dv_rem_in[k]  = b_num_r;
      assign dv_den_in[k]  = b_den_r;
      assign dv_quot_in[k] = '0;
      assign dv_kind_in[k] = b_kind_r;
      assign dv_sup_in[k]  = b_sup_r;
    end else begin : g_next
      assign dv_vld_in[k]  = dv_vld_r[k-1];
      assign dv_rem_in[k]  = dv_rem_r[k-1];
      assign dv_den_in[k]  = dv_den_r[k-1];
      assign dv_quot_in[k] = dv_quot_r[k-1];
      assign dv_kind_in[k] = dv_kind_r[k-1];
      assign dv_sup_in[k]  = dv_sup_r[k-1];
    end

    assign diff   = {1'b0, dv_rem_in[k], 1'b0} - {2'b00, dv_den_in[k]};
    assign borrow = diff[DW+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k] <= dv_vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[k]  <= borrow ? {dv_rem_in[k][DW-2:0], 1'b0} : diff[DW-1:0];
        dv_den_r[k]  <= dv_den_in[k];
        dv_quot_r[k] <= {dv_quot_in[k][FW-2:0], !borrow};
        dv_kind_r[k] <= dv_kind_in[k];
        dv_sup_r[k]  <= dv_sup_in[k];
      end
    end
  end

  always_comb begin
    unique case (dv_kind_r[FW-1])
      KIND_ZERO: deg_nxt = '0;
      KIND_ONE:  deg_nxt = {1'b1, {FW{1'b0}}};
      KIND_RISE: deg_nxt = {1'b0, dv_quot_r[FW-1]};
      KIND_FALL: deg_nxt = {1'b0, dv_quot_r[FW-1]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld_r[FW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_degree_r <= DEGREE_W'(deg_nxt);
      out_sup_r    <= dv_sup_r[FW-1];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.degree     = out_degree_r;
  assign out_ch.in_support = out_sup_r;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import tm_pkg::*;
();

  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 15;
  localparam int LATENCY     = FRAC_BITS + 3;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_ITEMS  = 95;

  typedef logic [DATA_WIDTH-1:0] sample_t;

  class membership_board;
    typedef struct packed {
      logic [DEGREE_W-1:0] degree;
      logic                in_support;
    } grade_t;

    sample_t corner [4];
    grade_t  expected_grades [$];
    int      errors;

    function new();
      corner[CFG_CORNER_ONE]   = CORNER_MIN;
      corner[CFG_CORNER_TWO]   = CORNER_MIN;
      corner[CFG_CORNER_THREE] = CORNER_MAX;
      corner[CFG_CORNER_FOUR]  = CORNER_MAX;
      errors = 0;
    endfunction

    function void set_corner(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      corner[idx] = value;
    endfunction

    function logic [DEGREE_W-1:0] ramp_quotient(sample_t num, sample_t den);
      logic [47:0] wide;
      if (den == '0) return '0;
      wide = ({32'd0, num} << FRAC_BITS) / {32'd0, den};
      return wide[DEGREE_W-1:0];
    endfunction

    function grade_t grade_of(sample_t s);
      grade_t  g;
      sample_t a, b, c, d;
      a = corner[CFG_CORNER_ONE];
      b = corner[CFG_CORNER_TWO];
      c = corner[CFG_CORNER_THREE];
      d = corner[CFG_CORNER_FOUR];
      if (s <= a) g.degree = '0;
      else if (s < b) g.degree = ramp_quotient(s - a, b - a);
      else if (s <= c) g.degree = DEGREE_W'(1) << FRAC_BITS;
      else if (s < d) g.degree = ramp_quotient(d - s, d - c);
      else g.degree = '0;
      g.in_support = (s >= a) && (s <= d);
      return g;
    endfunction

    function void note_sample(sample_t s);
      expected_grades.push_back(grade_of(s));
    endfunction

    function void check_result(logic [DEGREE_W-1:0] degree, logic in_support);
      grade_t g;
      if (expected_grades.size() == 0) begin
        $error("result with nothing pending: degree %0d in_support %0b", degree, in_support);
        errors++;
        return;
      end
      g = expected_grades.pop_front();
      if (degree !== g.degree) begin
        $error("degree expected %0d actual %0d", g.degree, degree);
        errors++;
      end
      if (in_support !== g.in_support) begin
        $error("in_support expected %0b actual %0b", g.in_support, in_support);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   gaps_on;
  bit   stalls_on;

  membership_board board = new();

  tm_cfg_if                            cfg_bus ();
  tm_in_if #(.DATA_WIDTH(DATA_WIDTH))  in_bus ();
  tm_out_if                            out_bus ();

  trapezoid_membership #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      board.check_result(out_bus.degree, out_bus.in_support);
  end

  initial begin : result_ready
    int hold;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && stalls_on && $urandom_range(0, 15) == 0)
        hold = $urandom_range(1, 17);
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        hold--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[trapezoid_membership] ERROR");
    $finish;
  end

  task automatic send_sample(input sample_t s);
    int gap;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= s;
    do @(posedge clk); while (!in_bus.ready);
    board.note_sample(s);
    @(negedge clk);
  endtask

  // drop valid, wait out the pipeline
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (board.expected_grades.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic load_corners(input sample_t a, input sample_t b, input sample_t c,
                              input sample_t d);
    sample_t vals [4];
    vals = '{a, b, c, d};
    @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= cfg_index_t'(i);
      cfg_bus.data  <= vals[i];
      do @(posedge clk); while (!cfg_bus.ready);
      board.set_corner(cfg_index_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    int k;
    if ($urandom_range(0, 1) == 1) return sample_t'($urandom_range(0, 65535));
    k = $urandom_range(0, 3);
    return board.corner[k] + sample_t'($urandom_range(0, 8)) - sample_t'(4);
  endfunction

  task automatic random_samples(input int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  initial begin : stimulus
    sample_t fixed_sets [7][4];
    sample_t rc [4];
    sample_t tmp;
    sample_t edge_samples [$];

    fixed_sets = '{
      '{16'd0,     16'd0,     16'd0,     16'd0},
      '{16'd65535, 16'd65535, 16'd65535, 16'd65535},
      '{16'd0,     16'd65535, 16'd65535, 16'd65535},
      '{16'd0,     16'd0,     16'd0,     16'd65535},
      '{16'd5000,  16'd5000,  16'd9000,  16'd9000},
      '{16'd60000, 16'd100,   16'd30000, 16'd200},
      '{16'd30000, 16'd30001, 16'd30002, 16'd30003}
    };

    rst_n         = 1'b0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    in_bus.valid  = 1'b0;
    in_bus.sample = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_CORNER_ONE;
    cfg_bus.data  = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // corners as left by reset
    edge_samples = '{16'd0, 16'd1, 16'd32768, 16'd65534, 16'd65535};
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    random_samples(RAND_ITEMS);
    drain();

    load_corners(16'd1000, 16'd20000, 16'd40000, 16'd60000);
    edge_samples = '{16'd0, 16'd999, 16'd1000, 16'd1001, 16'd19999, 16'd20000, 16'd20001,
                     16'd39999, 16'd40000, 16'd40001, 16'd59999, 16'd60000, 16'd60001,
                     16'd65535};
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    random_samples(RAND_ITEMS);
    drain();

    for (int p = 0; p < 7; p++) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      load_corners(fixed_sets[p][0], fixed_sets[p][1], fixed_sets[p][2], fixed_sets[p][3]);
      random_samples(RAND_ITEMS);
      drain();
    end

    for (int p = 0; p < 5; p++) begin
      for (int j = 0; j < 4; j++) rc[j] = sample_t'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) != 0) begin
        for (int j = 1; j < 4; j++) begin
          for (int k = j; k > 0 && rc[k-1] > rc[k]; k--) begin
            tmp     = rc[k];
            rc[k]   = rc[k-1];
            rc[k-1] = tmp;
          end
        end
      end
      gaps_on   = (p != 4);
      stalls_on = (p != 4);
      load_corners(rc[0], rc[1], rc[2], rc[3]);
      random_samples(RAND_ITEMS);
      drain();
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (board.errors == 0 && board.expected_grades.size() == 0)
      $display("[trapezoid_membership] OK");
    else
      $display("[trapezoid_membership] ERROR");
    $finish;
  end

endmodule

>>> sim.f
src/tm_pkg.sv
src/tm_in_if.sv
src/tm_out_if.sv
src/tm_cfg_if.sv
src/trapezoid_membership.sv
test/tb_top.sv
